[hdl/ccus_pkg.sv]
package ccus_pkg;

    localparam int CMD_W          = 2;
    localparam int TAG_W          = 32;
    localparam int SIZE_W         = 32;
    localparam int CRC_W          = 32;
    localparam int DATA_W         = 64;
    localparam int CNT_W          = 4;
    localparam int STORE_W        = 2;
    localparam int STATUS_W       = 3;
    localparam int BYTE_W         = 8;
    localparam int BYTES_PER_ITEM = 8;

    localparam logic [CRC_W-1:0]   CRC_POLY  = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]   CRC_ONES  = 32'hFFFF_FFFF;
    localparam logic [STORE_W-1:0] STORE_OK  = 2'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_STATE   = 3'd1,
        ST_BAD_CRC     = 3'd2,
        ST_NO_SPACE    = 3'd3,
        ST_IO_ERROR    = 3'd4,
        ST_UNAVAILABLE = 3'd5
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [TAG_W-1:0]   echo_tag;
        logic [SIZE_W-1:0]  bytes_received;
        logic [CRC_W-1:0]   final_check;
        logic               session_open;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_crc_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_crc_sts;

    // storage outcome 1..3 maps onto status 3..5
    function automatic t_status store_status(input logic [STORE_W-1:0] outcome);
        return t_status'(STATUS_W'(outcome) + STATUS_W'(2));
    endfunction

    function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ CRC_W'(data);
        for (int k = 0; k < BYTE_W; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

[hdl/ccus_ifs.sv]
interface ccus_req_if;
    logic                           valid;
    logic                           ready;
    logic [ccus_pkg::CMD_W-1:0]     command;
    logic [ccus_pkg::TAG_W-1:0]     transfer_tag;
    logic [ccus_pkg::SIZE_W-1:0]    byte_offset;
    logic [ccus_pkg::SIZE_W-1:0]    total_size;
    logic [ccus_pkg::CRC_W-1:0]     expected_check;
    logic [ccus_pkg::DATA_W-1:0]    data_bytes;
    logic [ccus_pkg::CNT_W-1:0]     byte_count;
    logic [ccus_pkg::STORE_W-1:0]   store_outcome;

    modport source (output valid, command, transfer_tag, byte_offset, total_size,
                    expected_check, data_bytes, byte_count, store_outcome,
                    input ready);
    modport sink (input valid, command, transfer_tag, byte_offset, total_size,
                  expected_check, data_bytes, byte_count, store_outcome,
                  output ready);
endinterface

interface ccus_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ccus_pkg::STATUS_W-1:0]  status;
    logic [ccus_pkg::TAG_W-1:0]     echo_tag;
    logic [ccus_pkg::SIZE_W-1:0]    bytes_received;
    logic [ccus_pkg::CRC_W-1:0]     final_check;
    logic                           session_open;

    modport source (output valid, status, echo_tag, bytes_received, final_check,
                    session_open, input ready);
    modport sink (input valid, status, echo_tag, bytes_received, final_check,
                  session_open, output ready);
endinterface

interface ccus_cfg_if;
    logic valid;
    logic ready;
    logic service_available;

    modport source (output valid, service_available, input ready);
    modport sink (input valid, service_available, output ready);
endinterface

[hdl/ccus_crc_unit.sv]
module ccus_crc_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ccus_pkg::t_crc_cmd           i_cmd,
    input  logic [ccus_pkg::CRC_W-1:0]   i_crc_init,
    input  logic [ccus_pkg::DATA_W-1:0]  i_data,
    output ccus_pkg::t_crc_sts           o_sts,
    output logic [ccus_pkg::CRC_W-1:0]   o_crc
);
    import ccus_pkg::*;

    logic [CRC_W-1:0]  r_crc;
    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  r_left;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_left <= i_cmd.count;
            r_done <= 1'b0;
        end else if (r_left != '0) begin
            r_left <= r_left - CNT_W'(1);
            r_done <= (r_left == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // fold the low byte each cycle, then shift the next one down
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_crc  <= i_crc_init;
            r_data <= i_data;
        end else if (r_left != '0) begin
            r_crc  <= crc_fold_byte(r_crc, r_data[BYTE_W-1:0]);
            r_data <= r_data >> BYTE_W;
        end
    end

    assign o_sts.busy = (r_left != '0);
    assign o_sts.done = r_done;
    assign o_crc      = r_crc;

endmodule

[hdl/ccus_ctrl.sv]
module ccus_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_service_available,
    ccus_req_if.sink                     i_req,
    input  ccus_pkg::t_crc_sts           i_crc_sts,
    input  logic [ccus_pkg::CRC_W-1:0]   i_crc,
    output ccus_pkg::t_crc_cmd           o_crc_cmd,
    output logic [ccus_pkg::CRC_W-1:0]   o_crc_init,
    output logic [ccus_pkg::DATA_W-1:0]  o_crc_data,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output ccus_pkg::t_result            o_res
);
    import ccus_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_FOLD = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // captured request
    t_cmd               r_cmd;
    logic [TAG_W-1:0]   r_tag;
    logic [SIZE_W-1:0]  r_off;
    logic [SIZE_W-1:0]  r_size;
    logic [CRC_W-1:0]   r_check;
    logic [DATA_W-1:0]  r_data;
    logic [CNT_W-1:0]   r_count;
    logic [STORE_W-1:0] r_store;

    // session state
    logic               r_open,     n_open;
    logic [TAG_W-1:0]   r_stag,     n_stag;
    logic [SIZE_W-1:0]  r_exp_tot,  n_exp_tot;
    logic [CRC_W-1:0]   r_exp_crc,  n_exp_crc;
    logic [SIZE_W-1:0]  r_rcv,      n_rcv;
    logic [CRC_W-1:0]   r_run_crc,  n_run_crc;

    t_result            r_res,      n_res;

    logic               data_bad;
    logic               commit_bad;
    logic [CRC_W-1:0]   crc_final;
    logic [SIZE_W:0]    data_end;

    assign data_end   = {1'b0, r_off} + (SIZE_W+1)'(r_count);
    assign data_bad   = (r_count > CNT_W'(BYTES_PER_ITEM)) || !r_open || (r_tag != r_stag) ||
                        (r_off != r_rcv) || (data_end > {1'b0, r_exp_tot});
    assign crc_final  = r_run_crc ^ CRC_ONES;
    assign commit_bad = !r_open || (r_tag != r_stag) || (r_rcv != r_exp_tot);

    always_comb begin
        n_state   = r_state;
        n_open    = r_open;
        n_stag    = r_stag;
        n_exp_tot = r_exp_tot;
        n_exp_crc = r_exp_crc;
        n_rcv     = r_rcv;
        n_run_crc = r_run_crc;
        n_res     = r_res;
        o_crc_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_res   = '0;
                n_state = S_DONE;
                if (!i_service_available || r_cmd == CMD_NONE) begin
                    n_res.status = ST_UNAVAILABLE;
                end else begin
                    case (r_cmd)
                        CMD_BEGIN: begin
                            n_open    = 1'b0;
                            n_stag    = '0;
                            n_exp_tot = '0;
                            n_rcv     = '0;
                            n_run_crc = CRC_ONES;
                            if (r_store != STORE_OK) begin
                                n_res.status = store_status(r_store);
                            end else begin
                                n_open           = 1'b1;
                                n_stag           = r_tag;
                                n_exp_tot        = r_size;
                                n_exp_crc        = r_check;
                                n_res.echo_tag   = r_tag;
                            end
                        end
                        CMD_DATA: begin
                            if (data_bad) begin
                                n_res.status = ST_BAD_STATE;
                            end else if (r_store != STORE_OK) begin
                                n_res.status = store_status(r_store);
                                n_open       = 1'b0;
                                n_stag       = '0;
                                n_exp_tot    = '0;
                                n_rcv        = '0;
                                n_run_crc    = CRC_ONES;
                            end else begin
                                n_rcv                = r_rcv + SIZE_W'(r_count);
                                n_res.echo_tag       = r_tag;
                                n_res.bytes_received = r_rcv + SIZE_W'(r_count);
                                if (r_count != '0) begin
                                    o_crc_cmd.start = 1'b1;
                                    o_crc_cmd.count = r_count;
                                    n_state         = S_FOLD;
                                end
                            end
                        end
                        CMD_COMMIT: begin
                            if (commit_bad) begin
                                n_res.status = ST_BAD_STATE;
                            end else if (crc_final != r_exp_crc) begin
                                n_res.status = ST_BAD_CRC;
                                n_open       = 1'b0;
                                n_stag       = '0;
                                n_exp_tot    = '0;
                                n_rcv        = '0;
                                n_run_crc    = CRC_ONES;
                            end else begin
                                n_open = 1'b0;
                                if (r_store != STORE_OK) begin
                                    n_res.status = store_status(r_store);
                                end else begin
                                    n_res.echo_tag       = r_tag;
                                    n_res.bytes_received = r_rcv;
                                    n_res.final_check    = crc_final;
                                    n_stag               = '0;
                                end
                            end
                        end
                        default: begin
                            n_res.status = ST_UNAVAILABLE;
                        end
                    endcase
                end
                n_res.session_open = n_open;
            end
            S_FOLD: begin
                // hold until the last byte has been folded
                if (i_crc_sts.done) begin
                    n_run_crc = i_crc;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_open    <= 1'b0;
            r_stag    <= '0;
            r_exp_tot <= '0;
            r_exp_crc <= '0;
            r_rcv     <= '0;
            r_run_crc <= CRC_ONES;
        end else begin
            r_state   <= n_state;
            r_open    <= n_open;
            r_stag    <= n_stag;
            r_exp_tot <= n_exp_tot;
            r_exp_crc <= n_exp_crc;
            r_rcv     <= n_rcv;
            r_run_crc <= n_run_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_req.valid && i_req.ready) begin
            r_cmd   <= t_cmd'(i_req.command);
            r_tag   <= i_req.transfer_tag;
            r_off   <= i_req.byte_offset;
            r_size  <= i_req.total_size;
            r_check <= i_req.expected_check;
            r_data  <= i_req.data_bytes;
            r_count <= i_req.byte_count;
            r_store <= i_req.store_outcome;
        end
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_crc_init   = r_run_crc;
    assign o_crc_data   = r_data;
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;

endmodule

[hdl/crc_checked_upload_session_unit.sv]
// Channel    Dir  Handshake      Payload
// i_req      in   valid/ready    command, tag, offset, size, expected crc, data, count, store
// o_rsp      out  valid/ready    status, echo tag, bytes received, final crc, session open
// i_cfg      in   valid/ready    service_available (always ready)
//
// A request steps through idle, evaluate and done; a data request that folds bytes
// also waits in the fold step on the byte-serial CRC unit; ready is high only while idle.
// A finished response sits in the output register while the next request is taken.
// Reset (synchronous, active low) closes the session and sets the running CRC to all ones.
// A stalled response holds the sequencer in its done step until the output register frees.
module crc_checked_upload_session_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ccus_req_if.sink     i_req,
    ccus_rsp_if.source   o_rsp,
    ccus_cfg_if.sink     i_cfg
);
    import ccus_pkg::*;

    logic               r_svc;
    logic               r_out_valid;
    t_result            r_out;

    t_crc_cmd           crc_cmd;
    t_crc_sts           crc_sts;
    logic [CRC_W-1:0]   crc_init;
    logic [DATA_W-1:0]  crc_data;
    logic [CRC_W-1:0]   crc_value;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    ccus_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_service_available (r_svc),
        .i_req               (i_req),
        .i_crc_sts           (crc_sts),
        .i_crc               (crc_value),
        .o_crc_cmd           (crc_cmd),
        .o_crc_init          (crc_init),
        .o_crc_data          (crc_data),
        .o_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .o_res               (res)
    );

    ccus_crc_unit u_crc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (crc_cmd),
        .i_crc_init (crc_init),
        .i_data     (crc_data),
        .o_sts      (crc_sts),
        .o_crc      (crc_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svc <= 1'b0;
        end else if (i_cfg.valid) begin
            r_svc <= i_cfg.service_available;
        end
    end

    assign i_cfg.ready = 1'b1;

    // output register: load when empty or being drained
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.echo_tag       = r_out.echo_tag;
    assign o_rsp.bytes_received = r_out.bytes_received;
    assign o_rsp.final_check    = r_out.final_check;
    assign o_rsp.session_open   = r_out.session_open;

endmodule

[bench/crc_checked_upload_session_unit_test.sv]
`timescale 1ns / 100ps

module crc_checked_upload_session_unit_test;

    import ccus_pkg::*;

    localparam int STALL_LIMIT       = 2000;
    localparam int RSP_HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES      = 20;
    localparam int IDLE_PERCENT      = 19;
    localparam int NUM_PHASES        = 5;

    typedef struct packed {
        t_cmd                 cmd;
        logic [TAG_W-1:0]     tag;
        logic [SIZE_W-1:0]    offset;
        logic [SIZE_W-1:0]    total;
        logic [CRC_W-1:0]     check;
        logic [DATA_W-1:0]    data;
        logic [CNT_W-1:0]     count;
        logic [STORE_W-1:0]   store;
    } upload_req_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_CONFIG
    } plan_kind_t;

    typedef struct {
        plan_kind_t  kind;
        upload_req_t req;
        bit          pinned;
        t_result     res;
        bit          svc;
    } plan_row_t;

    logic clk;
    logic rst_n;

    ccus_req_if req_if();
    ccus_rsp_if rsp_if();
    ccus_cfg_if cfg_if();

    crc_checked_upload_session_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // session tracker state
    bit                 svc_avail;
    bit                 sess_open;
    logic [TAG_W-1:0]   sess_tag;
    logic [SIZE_W-1:0]  sess_total;
    logic [CRC_W-1:0]   sess_crc_goal;
    logic [SIZE_W-1:0]  sess_rcvd;
    logic [CRC_W-1:0]   sess_crc_run;

    t_result     upload_replies_due[$];
    plan_row_t   plan[$];

    bit no_idle;
    bit rsp_hold_req;
    int items_sent;
    int replies_checked;
    int fail_count;
    int commits_clean;
    int commits_bad_crc;
    int service_writes;
    int stall_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CRC_W-1:0] crc_add_bytes(input logic [CRC_W-1:0] seed,
                                                       input logic [DATA_W-1:0] bytes,
                                                       input int n);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = seed;
        // bit-serial, LSB of byte 0 first
        for (int i = 0; i < n * BYTE_W; i++) begin
            fb = c[0] ^ bytes[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void close_session();
        sess_open    = 1'b0;
        sess_tag     = '0;
        sess_total   = '0;
        sess_rcvd    = '0;
        sess_crc_run = CRC_ONES;
    endfunction

    function automatic t_status storage_fail(input logic [STORE_W-1:0] store);
        case (store)
            2'd1:    return ST_NO_SPACE;
            2'd2:    return ST_IO_ERROR;
            default: return ST_UNAVAILABLE;
        endcase
    endfunction

    function automatic t_result predict_upload(input upload_req_t r);
        t_result           res;
        logic [SIZE_W:0]   span;
        logic [CRC_W-1:0]  crc;
        res        = '0;
        res.status = ST_OK;
        span       = {1'b0, r.offset} + (SIZE_W + 1)'(r.count);
        crc        = sess_crc_run ^ CRC_ONES;
        if (!svc_avail || r.cmd == CMD_NONE) begin
            res.status = ST_UNAVAILABLE;
        end else if (r.cmd == CMD_BEGIN) begin
            close_session();
            if (r.store != STORE_OK) begin
                res.status = storage_fail(r.store);
            end else begin
                sess_open     = 1'b1;
                sess_tag      = r.tag;
                sess_total    = r.total;
                sess_crc_goal = r.check;
                res.echo_tag  = r.tag;
            end
        end else if (r.cmd == CMD_DATA) begin
            if (r.count > BYTES_PER_ITEM || !sess_open || r.tag != sess_tag ||
                r.offset != sess_rcvd || span > {1'b0, sess_total}) begin
                res.status = ST_BAD_STATE;
            end else if (r.store != STORE_OK) begin
                res.status = storage_fail(r.store);
                close_session();
            end else begin
                sess_crc_run       = crc_add_bytes(sess_crc_run, r.data, int'(r.count));
                sess_rcvd          = sess_rcvd + SIZE_W'(r.count);
                res.echo_tag       = r.tag;
                res.bytes_received = sess_rcvd;
            end
        end else begin
            if (!sess_open || r.tag != sess_tag || sess_rcvd != sess_total) begin
                res.status = ST_BAD_STATE;
            end else if (crc != sess_crc_goal) begin
                res.status = ST_BAD_CRC;
                commits_bad_crc++;
                close_session();
            end else begin
                sess_open = 1'b0;
                if (r.store != STORE_OK) begin
                    res.status = storage_fail(r.store);
                end else begin
                    res.echo_tag       = r.tag;
                    res.bytes_received = sess_rcvd;
                    res.final_check    = crc;
                    sess_tag           = '0;
                    commits_clean++;
                end
            end
        end
        res.session_open = sess_open;
        return res;
    endfunction

    function automatic upload_req_t mk_req(input t_cmd cmd,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [SIZE_W-1:0] offset,
                                           input logic [SIZE_W-1:0] total,
                                           input logic [CRC_W-1:0] check,
                                           input logic [DATA_W-1:0] data,
                                           input logic [CNT_W-1:0] count,
                                           input logic [STORE_W-1:0] store);
        upload_req_t r;
        r.cmd    = cmd;
        r.tag    = tag;
        r.offset = offset;
        r.total  = total;
        r.check  = check;
        r.data   = data;
        r.count  = count;
        r.store  = store;
        return r;
    endfunction

    function automatic t_result mk_res(input t_status status, input logic [TAG_W-1:0] echo,
                                       input logic open);
        t_result res;
        res              = '0;
        res.status       = status;
        res.echo_tag     = echo;
        res.session_open = open;
        return res;
    endfunction

    function automatic void add_checked(input upload_req_t r);
        plan_row_t row;
        row.kind   = ROW_REQUEST;
        row.req    = r;
        row.pinned = 1'b0;
        row.res    = '0;
        row.svc    = 1'b0;
        plan.push_back(row);
    endfunction

    function automatic void add_pinned(input upload_req_t r, input t_result res);
        plan_row_t row;
        row.kind   = ROW_REQUEST;
        row.req    = r;
        row.pinned = 1'b1;
        row.res    = res;
        row.svc    = 1'b0;
        plan.push_back(row);
    endfunction

    function automatic void add_config(input bit v);
        plan_row_t row;
        row.kind   = ROW_CONFIG;
        row.req    = '0;
        row.pinned = 1'b0;
        row.res    = '0;
        row.svc    = v;
        plan.push_back(row);
    endfunction

    function automatic upload_req_t noise_request(input logic [TAG_W-1:0] tag_hint);
        upload_req_t r;
        r.cmd    = t_cmd'($urandom_range(3));
        r.tag    = $urandom_range(1) ? tag_hint : $urandom;
        r.offset = $urandom_range(1) ? $urandom : SIZE_W'($urandom_range(64));
        r.total  = $urandom;
        r.check  = $urandom;
        r.data   = {$urandom, $urandom};
        r.count  = CNT_W'($urandom_range(15));
        r.store  = STORE_W'($urandom_range(3));
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic issue_request(input upload_req_t r, input bit pinned,
                                 input t_result pinned_res);
        t_result due;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                req_if.valid = 1'b0;
                @(negedge clk);
            end
        end
        req_if.command        = r.cmd;
        req_if.transfer_tag   = r.tag;
        req_if.byte_offset    = r.offset;
        req_if.total_size     = r.total;
        req_if.expected_check = r.check;
        req_if.data_bytes     = r.data;
        req_if.byte_count     = r.count;
        req_if.store_outcome  = r.store;
        req_if.valid          = 1'b1;
        do @(posedge clk); while (!req_if.ready);
        due = predict_upload(r);
        if (pinned) begin
            due = pinned_res;
        end
        upload_replies_due.push_back(due);
        items_sent++;
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    task automatic settle_replies();
        while (upload_replies_due.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_service(input bit v);
        settle_replies();
        cfg_if.service_available = v;
        cfg_if.valid             = 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        svc_avail = v;
        service_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic run_session();
        logic [TAG_W-1:0]   tag;
        logic [CRC_W-1:0]   crc;
        logic [CRC_W-1:0]   check;
        logic [SIZE_W-1:0]  total;
        logic [SIZE_W-1:0]  sent;
        logic [DATA_W-1:0]  chunk_data[$];
        int                 chunk_len[$];
        int                 n;
        int                 len;
        logic [DATA_W-1:0]  d;
        logic [STORE_W-1:0] store;
        tag   = $urandom;
        crc   = CRC_ONES;
        total = '0;
        sent  = '0;
        n     = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
            len = $urandom_range(BYTES_PER_ITEM);
            d   = {$urandom, $urandom};
            chunk_data.push_back(d);
            chunk_len.push_back(len);
            crc   = crc_add_bytes(crc, d, len);
            total = total + SIZE_W'(len);
        end
        check = crc ^ CRC_ONES;
        if ($urandom_range(7) == 0) begin
            check = check ^ (CRC_W'(1) << $urandom_range(31));
        end
        if ($urandom_range(9) == 0) begin
            total = total + SIZE_W'($urandom_range(1, 3));
        end
        store = ($urandom_range(99) < 92) ? STORE_OK : STORE_W'($urandom_range(1, 3));
        issue_request(mk_req(CMD_BEGIN, tag, $urandom, total, check, {$urandom, $urandom},
                             CNT_W'($urandom_range(15)), store), 1'b0, '0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 6) begin
                issue_request(noise_request(tag), 1'b0, '0);
            end
            // drop a chunk now and then so the offsets after it go stale
            if ($urandom_range(19) != 0) begin
                store = ($urandom_range(99) < 96) ? STORE_OK : STORE_W'($urandom_range(1, 3));
                issue_request(mk_req(CMD_DATA, tag, sent, $urandom, $urandom, chunk_data[i],
                                     CNT_W'(chunk_len[i]), store), 1'b0, '0);
            end
            sent = sent + SIZE_W'(chunk_len[i]);
        end
        if ($urandom_range(14) != 0) begin
            store = ($urandom_range(99) < 90) ? STORE_OK : STORE_W'($urandom_range(1, 3));
            issue_request(mk_req(CMD_COMMIT, ($urandom_range(19) == 0) ? $urandom : tag,
                                 $urandom, $urandom, $urandom, {$urandom, $urandom},
                                 CNT_W'($urandom_range(15)), store), 1'b0, '0);
        end
    endtask

    // response side: random stalls, plus one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                rsp_if.ready = 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
            end
            rsp_if.ready = no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk) begin
        t_result due;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (upload_replies_due.size() == 0) begin
                $error("response arrived with no request outstanding");
                fail_count++;
            end else begin
                due = upload_replies_due.pop_front();
                replies_checked++;
                if (rsp_if.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.echo_tag !== due.echo_tag) begin
                    $error("echo_tag: expected %h, got %h", due.echo_tag, rsp_if.echo_tag);
                    fail_count++;
                end
                if (rsp_if.bytes_received !== due.bytes_received) begin
                    $error("bytes_received: expected %0d, got %0d",
                           due.bytes_received, rsp_if.bytes_received);
                    fail_count++;
                end
                if (rsp_if.final_check !== due.final_check) begin
                    $error("final_check: expected %h, got %h",
                           due.final_check, rsp_if.final_check);
                    fail_count++;
                end
                if (rsp_if.session_open !== due.session_open) begin
                    $error("session_open: expected %0b, got %0b",
                           due.session_open, rsp_if.session_open);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("crc_checked_upload_session_unit regression: fail");
        $finish;
    end

    initial begin
        int  phase_budget[NUM_PHASES];
        bit  phase_svc[NUM_PHASES];
        int  target;
        bit  paused;
        logic [DATA_W-1:0] four_bytes;

        rst_n                    = 1'b0;
        req_if.valid             = 1'b0;
        req_if.command           = CMD_BEGIN;
        req_if.transfer_tag      = '0;
        req_if.byte_offset       = '0;
        req_if.total_size        = '0;
        req_if.expected_check    = '0;
        req_if.data_bytes        = '0;
        req_if.byte_count        = '0;
        req_if.store_outcome     = STORE_OK;
        cfg_if.valid             = 1'b0;
        cfg_if.service_available = 1'b0;
        no_idle                  = 1'b0;
        rsp_hold_req             = 1'b0;
        items_sent               = 0;
        replies_checked          = 0;
        fail_count               = 0;
        commits_clean            = 0;
        commits_bad_crc          = 0;
        service_writes           = 0;
        svc_avail                = 1'b0;
        sess_crc_goal            = '0;
        close_session();

        phase_budget = '{300, 250, 250, 40, 310};
        phase_svc    = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        four_bytes   = 64'h0000_0000_0403_0201;

        // service is off after reset
        add_pinned(mk_req(CMD_BEGIN, 32'h1, '0, 32'd8, '0, '0, '0, STORE_OK),
                   mk_res(ST_UNAVAILABLE, '0, 1'b0));
        add_config(1'b1);
        add_pinned(mk_req(CMD_NONE, '0, '0, '0, '0, '0, '0, STORE_OK),
                   mk_res(ST_UNAVAILABLE, '0, 1'b0));
        add_pinned(mk_req(CMD_DATA, '0, '0, '0, '0, '1, 4'd1, STORE_OK),
                   mk_res(ST_BAD_STATE, '0, 1'b0));
        add_pinned(mk_req(CMD_COMMIT, '0, '0, '0, '0, '0, '0, STORE_OK),
                   mk_res(ST_BAD_STATE, '0, 1'b0));
        add_pinned(mk_req(CMD_BEGIN, '1, '0, 32'd16, '0, '0, '0, STORE_OK),
                   mk_res(ST_OK, '1, 1'b1));
        add_pinned(mk_req(CMD_DATA, '1, '0, '0, '0, '1, 4'd9, STORE_OK),
                   mk_res(ST_BAD_STATE, '0, 1'b1));
        add_checked(mk_req(CMD_DATA, '1, '0, '0, '0, '1, 4'd0, STORE_OK));
        add_checked(mk_req(CMD_DATA, '1, '0, '1, '1, '1, 4'd8, STORE_OK));
        add_pinned(mk_req(CMD_DATA, '1, '0, '0, '0, '1, 4'd8, STORE_OK),
                   mk_res(ST_BAD_STATE, '0, 1'b1));
        add_pinned(mk_req(CMD_DATA, 32'h7FFF_FFFF, 32'd8, '0, '0, '0, 4'd8, STORE_OK),
                   mk_res(ST_BAD_STATE, '0, 1'b1));
        add_checked(mk_req(CMD_DATA, '1, 32'd8, '0, '0, '0, 4'd8, STORE_OK));
        add_pinned(mk_req(CMD_DATA, '1, 32'd16, '0, '0, '1, 4'd1, STORE_OK),
                   mk_res(ST_BAD_STATE, '0, 1'b1));
        add_checked(mk_req(CMD_COMMIT, '1, '0, '0, '0, '0, '0, STORE_OK));
        add_checked(mk_req(CMD_BEGIN, 32'h5, '0, 32'd4,
                           crc_add_bytes(CRC_ONES, four_bytes, 4) ^ CRC_ONES,
                           '0, '0, STORE_OK));
        add_checked(mk_req(CMD_DATA, 32'h5, '0, '0, '0, four_bytes, 4'd4, 2'd2));
        add_pinned(mk_req(CMD_BEGIN, 32'h5, '0, 32'd4, '0, '0, '0, 2'd1),
                   mk_res(ST_NO_SPACE, '0, 1'b0));
        add_checked(mk_req(CMD_BEGIN, 32'h5, '0, 32'd4,
                           crc_add_bytes(CRC_ONES, four_bytes, 4) ^ CRC_ONES,
                           '0, '0, STORE_OK));
        add_checked(mk_req(CMD_DATA, 32'h5, '0, '0, '0, four_bytes, 4'd4, STORE_OK));
        add_checked(mk_req(CMD_COMMIT, 32'h5, '0, '0, '0, '0, '0, 2'd3));
        add_checked(mk_req(CMD_BEGIN, 32'h6, '0, '0, '0, '0, '0, STORE_OK));
        add_checked(mk_req(CMD_COMMIT, 32'h6, '0, '0, '0, '0, '0, STORE_OK));
        add_checked(mk_req(CMD_BEGIN, 32'h7, '0, '1, 32'hDEAD_BEEF, '0, '0, STORE_OK));
        add_checked(mk_req(CMD_DATA, 32'h7, '0, '0, '0, 64'h0123_4567_89AB_CDEF, 4'd8,
                           STORE_OK));
        add_config(1'b0);
        add_pinned(mk_req(CMD_COMMIT, 32'h7, '0, '0, '0, '0, '0, STORE_OK),
                   mk_res(ST_UNAVAILABLE, '0, 1'b1));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CONFIG) begin
                write_service(plan[i].svc);
            end else begin
                issue_request(plan[i].req, plan[i].pinned, plan[i].res);
            end
        end

        paused = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_service(phase_svc[p]);
            no_idle = (p == 1);
            // hold the response side while requests keep coming
            if (p == 2) begin
                rsp_hold_req = 1'b1;
            end
            target = items_sent + phase_budget[p];
            while (items_sent < target) begin
                if (p == 4 && !paused && items_sent > target - phase_budget[p] / 2) begin
                    paused = 1'b1;
                    settle_replies();
                end
                run_session();
            end
        end
        no_idle = 1'b0;

        settle_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests over %0d service writes, %0d responses compared",
                 items_sent, service_writes, replies_checked);
        $display("sessions: %0d committed cleanly, %0d rejected on crc, %0d mismatches",
                 commits_clean, commits_bad_crc, fail_count);
        if (fail_count == 0 && upload_replies_due.size() == 0) begin
            $display("crc_checked_upload_session_unit regression: pass");
        end else begin
            $display("crc_checked_upload_session_unit regression: fail");
        end
        $finish;
    end

endmodule
